>>> design/sha256_message_hash_unit_defines.svh
// assertion macros for the sha256 hash unit
`ifndef SHA256_MESSAGE_HASH_UNIT_DEFINES_SVH
`define SHA256_MESSAGE_HASH_UNIT_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define SHA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication outside reset
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/sha_pkg.sv
package sha_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned CntW = 61;
  localparam int unsigned NumRounds = 64;

  localparam logic [255:0] InitH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // datapath commands from the controller
  typedef struct packed {
    logic put_byte;     // store msg_byte at current position, count it
    logic put_pad;      // store 0x80 at current position
    logic put_len;      // write bit length into words 14 and 15
    logic start_comp;   // load working vars from chain value, round 0
    logic round;        // run one round
    logic finish_comp;  // add working vars into chain value, clear buffer
    logic shift_out;    // rotate chain value one word toward output
    logic restart;      // return to message start state
  } cmd_t;

  typedef struct packed {
    logic [5:0] pos;      // byte position within block
    logic       last_rnd; // round counter at 63
  } status_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    case (t)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    round_k = k;
  endfunction

endpackage

>>> design/sha_in_if.sv
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       has_byte;
  logic       end_of_message;
  modport source (output valid, msg_byte, has_byte, end_of_message, input ready);
  modport sink (input valid, msg_byte, has_byte, end_of_message, output ready);
endinterface

>>> design/sha_out_if.sv
interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

>>> design/sha_datapath.sv
module sha_datapath
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  input  logic [7:0] msg_byte,
  output status_t    status,
  output word_t      out_word
);

  word_t           h_r [8];
  word_t           w_r [16];
  word_t           v_r [8];
  logic [5:0]      rnd_r;
  logic [CntW-1:0] cnt_r;

  logic [5:0]  pos;
  logic [7:0]  put_val;
  logic [3:0]  widx;
  logic [1:0]  bsel;
  word_t       w_new, t1, t2, s0, s1, e1, e0, ch, mj, wt;
  logic [63:0] bits;

  assign pos     = cnt_r[5:0];
  assign widx    = pos[5:2];
  assign bsel    = pos[1:0];
  assign put_val = cmd.put_pad ? 8'h80 : msg_byte;
  assign bits    = {cnt_r, 3'b000};
  assign wt      = w_r[0];

  always_comb begin
    s0    = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1    = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = w_r[0] + s0 + w_r[9] + s1;
    e1    = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1    = v_r[7] + e1 + ch + round_k(rnd_r) + wt;
    e0    = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    mj    = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2    = e0 + mj;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      for (int i = 0; i < 8; i++) h_r[i] <= InitH[255 - 32*i -: 32];
      for (int i = 0; i < 16; i++) w_r[i] <= '0;
      cnt_r <= '0;
      rnd_r <= '0;
    end else begin
      if (cmd.put_byte || cmd.put_pad) begin
        w_r[widx] <= w_r[widx] | ({24'd0, put_val} << ({3'd0, ~bsel} * 5'd8));
      end
      if (cmd.put_byte) cnt_r <= cnt_r + 1'b1;
      if (cmd.put_len) begin
        w_r[14] <= bits[63:32];
        w_r[15] <= bits[31:0];
      end
      if (cmd.start_comp) begin
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
        rnd_r <= '0;
      end
      if (cmd.round) begin
        // message schedule runs as a 16-word shift window
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= w_new;
        v_r[7] <= v_r[6];
        v_r[6] <= v_r[5];
        v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2];
        v_r[2] <= v_r[1];
        v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
        rnd_r  <= rnd_r + 1'b1;
      end
      if (cmd.finish_comp) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
        for (int i = 0; i < 16; i++) w_r[i] <= '0;
      end
      if (cmd.shift_out) begin
        for (int i = 0; i < 7; i++) h_r[i] <= h_r[i+1];
        h_r[7] <= h_r[0];
      end
    end
  end

  assign status.pos      = pos;
  assign status.last_rnd = (rnd_r == 6'd63);
  assign out_word        = h_r[0];

endmodule

>>> design/sha_ctrl.sv
`include "sha256_message_hash_unit_defines.svh"
module sha_ctrl
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_has_byte,
  input  logic       in_eom,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [2:0] out_idx,
  input  status_t    status,
  output cmd_t       cmd
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StStart  = 3'd1;
  localparam logic [2:0] StRound  = 3'd2;
  localparam logic [2:0] StFinish = 3'd3;
  localparam logic [2:0] StPad    = 3'd4;
  localparam logic [2:0] StLen    = 3'd5;
  localparam logic [2:0] StOut    = 3'd6;

  // what to do after a compression finishes
  localparam logic [1:0] AftIdle = 2'd0;
  localparam logic [1:0] AftPad  = 2'd1;
  localparam logic [1:0] AftLen  = 2'd2;
  localparam logic [1:0] AftOut  = 2'd3;

  logic [2:0] state_r, state_nxt;
  logic [1:0] after_r, after_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       acc;

  assign in_ready  = (state_r == StIdle);
  assign acc       = in_valid && in_ready;
  assign out_valid = (state_r == StOut);
  assign out_idx   = idx_r;

  always_comb begin
    state_nxt = state_r;
    after_nxt = after_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    case (state_r)
      StIdle: begin
        if (acc) begin
          cmd.put_byte = in_has_byte;
          if (in_has_byte && status.pos == 6'd63) begin
            state_nxt = StStart;
            after_nxt = in_eom ? AftPad : AftIdle;
          end else if (in_eom) begin
            state_nxt = StPad;
          end
        end
      end
      StPad: begin
        cmd.put_pad = 1'b1;
        if (status.pos >= 6'd56) begin
          state_nxt = StStart;
          after_nxt = AftLen;
        end else begin
          state_nxt = StLen;
        end
      end
      StLen: begin
        cmd.put_len = 1'b1;
        state_nxt   = StStart;
        after_nxt   = AftOut;
      end
      StStart: begin
        cmd.start_comp = 1'b1;
        state_nxt      = StRound;
      end
      StRound: begin
        cmd.round = 1'b1;
        if (status.last_rnd) state_nxt = StFinish;
      end
      StFinish: begin
        cmd.finish_comp = 1'b1;
        idx_nxt         = '0;
        case (after_r)
          AftPad:  state_nxt = StPad;
          AftLen:  state_nxt = StLen;
          AftOut:  state_nxt = StOut;
          default: state_nxt = StIdle;
        endcase
      end
      StOut: begin
        if (out_ready) begin
          cmd.shift_out = 1'b1;
          idx_nxt       = idx_r + 1'b1;
          if (idx_r == 3'd7) begin
            cmd.restart = 1'b1;
            state_nxt   = StIdle;
          end
        end
      end
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      after_r <= AftIdle;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      after_r <= after_nxt;
      idx_r   <= idx_nxt;
    end
  end

  `SHA_ASSERT_NEXT(a_round_then_finish, state_r == StRound && status.last_rnd,
                   state_r == StFinish, "compression did not finish after last round")
  `SHA_ASSERT_NEXT(a_last_word_idle, out_valid && out_ready && idx_r == 3'd7,
                   state_r == StIdle, "unit not idle after last digest word")
  `SHA_ASSERT_IMP(a_no_accept_busy, state_r != StIdle, !in_ready,
                  "input ready while busy")
  `SHA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(idx_r), "digest word dropped while stalled")

endmodule

>>> design/sha256_message_hash_unit.sv
// sha-256 hash of a byte stream. one request carries a message byte (has_byte), an
// end-of-message flag, both or neither; the byte is taken before the message is
// closed. a byte request stores the byte into the block buffer, and every 64th byte
// of a block also starts a compression (64 rounds on one shared round unit, plus
// load and chain-value add). closing a message costs padding and one or two
// compressions, after which the eight digest words leave H0 first, one per accepted
// output cycle, with last_word on H7. the unit then starts the next message from
// the standard initial values. input ready is low while a compression or digest is
// in flight
`include "sha256_message_hash_unit_defines.svh"
module sha256_message_hash_unit
  import sha_pkg::*;
(
  input logic   clk,
  input logic   rst_n,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);

  cmd_t       cmd;
  status_t    status;
  word_t      out_word;
  logic [2:0] out_idx;

  // sequencing of byte packing, padding, rounds and digest output
  sha_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_has_byte(in_ch.has_byte),
    .in_eom     (in_ch.end_of_message),
    .in_ready   (in_ch.ready),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_idx    (out_idx),
    .status     (status),
    .cmd        (cmd)
  );

  // block buffer, schedule window, working variables and chain value
  sha_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .msg_byte(in_ch.msg_byte),
    .status  (status),
    .out_word(out_word)
  );

  assign out_ch.digest_word = out_word;
  assign out_ch.word_index  = out_idx;
  assign out_ch.last_word   = (out_idx == 3'd7);

  `SHA_ASSERT_IMP(a_last_flag, out_ch.valid && out_ch.last_word, out_idx == 3'd7,
                  "last word flag on wrong index")
  `SHA_ASSERT_IMP(a_exclusive, in_ch.ready, !out_ch.valid,
                  "input open while digest pending")
  `SHA_ASSERT_NEXT(a_word_step, out_ch.valid && out_ch.ready && out_idx != 3'd7,
                   out_ch.valid && out_idx == $past(out_idx) + 3'd1,
                   "digest words out of order")

endmodule

>>> test/tb_sha_types.sv
package tb_sha_types;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       end_of_message;
  } sha_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_digest_t;

endpackage

>>> test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sha_pkg::*;
  import tb_sha_types::*;

  logic clk;
  logic rst_n;

  sha_in_if  in_ch();
  sha_out_if out_ch();

  sha256_message_hash_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // round constants for the predictor, kept apart from the package function
  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // predictor state: running hash, block being filled, byte count
  logic [31:0] hash_h [8];
  logic [31:0] blk_w  [16];
  logic [60:0] msg_len;

  sha_req_t    req_q[$];      // requests waiting for the driver
  sha_digest_t digest_q[$];   // digest words still to come out
  int          err_cnt;
  bit          stim_done;
  bit          hold_src;      // sender hold-off until digests drain

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void hash_start();
    hash_h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
               32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    foreach (blk_w[i]) blk_w[i] = '0;
    msg_len = '0;
  endfunction

  function automatic void hash_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int t = 0; t < 16; t++) w[t] = blk_w[t];
    for (int t = 16; t < 64; t++)
      w[t] = w[t-16] + w[t-7]
           + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
           + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
    {a, b, c, d, e, f, g, h} = {hash_h[0], hash_h[1], hash_h[2], hash_h[3],
                                hash_h[4], hash_h[5], hash_h[6], hash_h[7]};
    for (int t = 0; t < 64; t++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
         + RoundK[t] + w[t];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d;
    hash_h[4] += e; hash_h[5] += f; hash_h[6] += g; hash_h[7] += h;
    foreach (blk_w[i]) blk_w[i] = '0;
  endfunction

  function automatic void pack_byte(logic [5:0] pos, logic [7:0] b);
    blk_w[pos[5:2]] |= 32'(b) << ((3 - pos[1:0]) * 8);
  endfunction

  // advance the predictor by one accepted request
  function automatic void hash_request(sha_req_t r);
    logic [5:0]  pos;
    logic [63:0] nbits;
    if (r.has_byte) begin
      pos = msg_len[5:0];
      pack_byte(pos, r.msg_byte);
      msg_len = msg_len + 1;
      if (pos == 6'd63) hash_block();
    end
    if (r.end_of_message) begin
      pos = msg_len[5:0];
      pack_byte(pos, 8'h80);
      if (pos >= 6'd56) hash_block();
      nbits = {msg_len, 3'b000};
      blk_w[14] = nbits[63:32];
      blk_w[15] = nbits[31:0];
      hash_block();
      for (int j = 0; j < 8; j++)
        digest_q.push_back('{digest_word: hash_h[j], word_index: 3'(j),
                             last_word: (j == 7)});
      hash_start();
    end
  endfunction

  function automatic void queue_msg(int len, int fill);
    sha_req_t r;
    for (int i = 0; i < len; i++) begin
      r.msg_byte = (fill < 0) ? 8'($urandom) : 8'(fill);
      r.has_byte = 1'b1;
      // sometimes the last byte closes the message itself
      r.end_of_message = (i == len - 1) && ($urandom_range(0, 1) == 1);
      req_q.push_back(r);
      if (r.end_of_message) return;
    end
    req_q.push_back('{msg_byte: 8'($urandom), has_byte: 1'b0, end_of_message: 1'b1});
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // driver: bursts of requests with random gaps
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.msg_byte <= '0;
      in_ch.has_byte <= 1'b0;
      in_ch.end_of_message <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid && in_ch.ready) hash_request(req_q.pop_front());
      if (hold_src || req_q.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else begin
        in_ch.valid <= 1'b1;
        {in_ch.msg_byte, in_ch.has_byte, in_ch.end_of_message} <= req_q[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: stall pattern alternating busy and quiet phases
  int stall_phase;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      out_ch.ready <= (stall_phase[7:6] == 2'b01) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // monitor: compare each digest word with the oldest prediction
  sha_digest_t want;
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (digest_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected digest word %h idx %0d", out_ch.digest_word,
                   out_ch.word_index);
      end else begin
        want = digest_q.pop_front();
        if (want.digest_word !== out_ch.digest_word ||
            want.word_index !== out_ch.word_index ||
            want.last_word !== out_ch.last_word) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                     want.digest_word, want.word_index, want.last_word,
                     out_ch.digest_word, out_ch.word_index, out_ch.last_word);
        end
      end
    end
  end

  initial begin
    int n;
    int q0;
    err_cnt = 0;
    stim_done = 0;
    hold_src = 0;
    hash_start();
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty message, "abc", an idle item, both padding boundaries
    req_q.push_back('{msg_byte: 8'h00, has_byte: 1'b0, end_of_message: 1'b1});
    req_q.push_back('{msg_byte: 8'h61, has_byte: 1'b1, end_of_message: 1'b0});
    req_q.push_back('{msg_byte: 8'hff, has_byte: 1'b0, end_of_message: 1'b0});
    req_q.push_back('{msg_byte: 8'h62, has_byte: 1'b1, end_of_message: 1'b0});
    req_q.push_back('{msg_byte: 8'h63, has_byte: 1'b1, end_of_message: 1'b1});
    req_q.push_back('{msg_byte: 8'hff, has_byte: 1'b1, end_of_message: 1'b1});
    req_q.push_back('{msg_byte: 8'h00, has_byte: 1'b1, end_of_message: 1'b1});
    queue_msg(55, 8'hff);
    queue_msg(56, 8'h00);
    queue_msg(64, 8'h5a);
    n = req_q.size();

    // pause the sender until every digest word has drained
    wait (req_q.size() == 0);
    hold_src = 1;
    wait (digest_q.size() == 0);
    @(posedge clk);
    hold_src = 0;

    // random messages, mostly short, a few spanning two blocks
    while (n < 220) begin
      q0 = req_q.size();
      case ($urandom_range(0, 9))
        0:       begin queue_msg($urandom_range(56, 80), -1); end
        1:       begin
          req_q.push_back('{msg_byte: 8'($urandom), has_byte: 1'b0, end_of_message: 1'b0});
        end
        default: begin queue_msg($urandom_range(0, 20), -1); end
      endcase
      n = n + req_q.size() - q0;
      while (req_q.size() > 40) @(posedge clk);
    end
    wait (req_q.size() == 0 && !in_ch.valid);
    wait (digest_q.size() == 0);
    repeat (300) @(posedge clk);
    if (err_cnt == 0 && digest_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
